[design/lcdt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lcdt_pkg;

    // Mode codes as seen on the result port.
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    localparam int unsigned LEN_HBLANK = 204;
    localparam int unsigned LEN_VBLANK = 456;
    localparam int unsigned LEN_OAM    = 80;
    localparam int unsigned LEN_XFER   = 172;

    localparam logic [7:0] LINE_VBLANK_START = 8'd144;
    localparam logic [7:0] LINE_LAST         = 8'd153;

    localparam int unsigned ACC_W  = 9;
    localparam int unsigned SUM_W  = 10;
    localparam int unsigned ADDR_W = 3;

    // Register indexes, taken from paddr[2].
    localparam logic REG_LINE_COMPARE = 1'b0;
    localparam logic REG_STAT_EN      = 1'b1;

    // Status interrupt enable bits.
    localparam int unsigned EN_HBLANK = 0;
    localparam int unsigned EN_VBLANK = 1;
    localparam int unsigned EN_OAM    = 2;
    localparam int unsigned EN_LYC    = 3;

    typedef enum logic [3:0] {
        ST_HBLANK = 4'b0001,
        ST_VBLANK = 4'b0010,
        ST_OAM    = 4'b0100,
        ST_XFER   = 4'b1000
    } t_mode_state;

    typedef struct packed {
        logic [7:0] line_compare;
        logic [3:0] stat_irq_enables;
    } t_cfg;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] line;
        logic       coincidence;
        logic       stat_irq;
        logic       vblank_irq;
        logic       in_vblank;
        logic       render_strobe;
        logic       search_strobe;
    } t_result;

    function automatic logic [1:0] mode_code(input t_mode_state st);
        logic [1:0] code;
        unique case (st)
            ST_HBLANK: code = MODE_HBLANK;
            ST_VBLANK: code = MODE_VBLANK;
            ST_OAM:    code = MODE_OAM;
            ST_XFER:   code = MODE_XFER;
            default:   code = MODE_HBLANK;
        endcase
        return code;
    endfunction

    function automatic logic [SUM_W-1:0] mode_length(input t_mode_state st);
        logic [SUM_W-1:0] len;
        unique case (st)
            ST_HBLANK: len = SUM_W'(LEN_HBLANK);
            ST_VBLANK: len = SUM_W'(LEN_VBLANK);
            ST_OAM:    len = SUM_W'(LEN_OAM);
            ST_XFER:   len = SUM_W'(LEN_XFER);
            default:   len = SUM_W'(LEN_HBLANK);
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[design/lcdt_apb.sv]
`timescale 1ns / 1ps
`default_nettype none

module lcdt_apb
    import lcdt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [7:0] r_line_compare;
    logic [3:0] r_stat_en;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_compare <= '0;
            r_stat_en      <= '0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_LINE_COMPARE: r_line_compare <= pwdata[7:0];
                REG_STAT_EN:      r_stat_en      <= pwdata[3:0];
                default:          r_stat_en      <= r_stat_en;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LINE_COMPARE: prdata = {24'd0, r_line_compare};
            REG_STAT_EN:      prdata = {28'd0, r_stat_en};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.line_compare     = r_line_compare;
    assign o_cfg.stat_irq_enables = r_stat_en;

endmodule

`default_nettype wire

[design/lcdt_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module lcdt_step
    import lcdt_pkg::*;
#(
    parameter int unsigned MAX_CYCLES = 24
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic       i_command,
    input  wire logic [4:0] i_cycles,
    input  wire t_cfg       i_cfg,
    output t_result         o_result
);

    localparam logic [6:0] MaxC = 7'(MAX_CYCLES);

    t_mode_state      r_mode, n_mode;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [7:0]       r_line, n_line;
    logic             r_coin, n_coin;
    logic             r_vblank, n_vblank;

    logic [6:0]       cyc_ext;
    logic [6:0]       cyc_sat;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] len;
    logic [SUM_W-1:0] rem;
    logic [7:0]       line_inc;
    logic             lyc_hit;
    logic             stat, vbi, rend, srch;

    assign cyc_ext  = {2'b00, i_cycles};
    assign cyc_sat  = (cyc_ext > MaxC) ? MaxC : cyc_ext;
    assign sum      = SUM_W'(r_acc) + SUM_W'(cyc_sat);
    assign len      = mode_length(r_mode);
    assign rem      = sum - len;
    assign line_inc = r_line + 8'd1;
    assign lyc_hit  = (line_inc == i_cfg.line_compare);

    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_line   = r_line;
        n_coin   = r_coin;
        n_vblank = r_vblank;
        stat     = 1'b0;
        vbi      = 1'b0;
        rend     = 1'b0;
        srch     = 1'b0;
        if (i_command) begin
            n_line = '0;
        end else if (sum >= len) begin
            n_acc = rem[ACC_W-1:0];
            unique case (r_mode)
                ST_HBLANK: begin
                    n_line = line_inc;
                    n_coin = lyc_hit;
                    stat   = lyc_hit && i_cfg.stat_irq_enables[EN_LYC];
                    if (line_inc == LINE_VBLANK_START) begin
                        n_mode   = ST_VBLANK;
                        n_vblank = 1'b1;
                        vbi      = 1'b1;
                        stat     = stat || i_cfg.stat_irq_enables[EN_VBLANK];
                    end else begin
                        n_mode = ST_OAM;
                        srch   = 1'b1;
                        stat   = stat || i_cfg.stat_irq_enables[EN_OAM];
                    end
                end
                ST_VBLANK: begin
                    n_line = line_inc;
                    n_coin = lyc_hit;
                    stat   = lyc_hit && i_cfg.stat_irq_enables[EN_LYC];
                    // The compare above sees line 154; only then does the line wrap.
                    if (line_inc > LINE_LAST) begin
                        n_line   = '0;
                        n_mode   = ST_OAM;
                        n_vblank = 1'b0;
                        srch     = 1'b1;
                        stat     = stat || i_cfg.stat_irq_enables[EN_OAM];
                    end
                end
                ST_OAM: begin
                    n_mode = ST_XFER;
                end
                ST_XFER: begin
                    n_mode = ST_HBLANK;
                    rend   = 1'b1;
                    stat   = i_cfg.stat_irq_enables[EN_HBLANK];
                end
                default: begin
                    n_mode = ST_HBLANK;
                end
            endcase
        end else begin
            n_acc = sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ST_HBLANK;
            r_acc    <= '0;
            r_line   <= '0;
            r_coin   <= 1'b0;
            r_vblank <= 1'b0;
        end else if (i_advance) begin
            r_mode   <= n_mode;
            r_acc    <= n_acc;
            r_line   <= n_line;
            r_coin   <= n_coin;
            r_vblank <= n_vblank;
        end
    end

    assign o_result.mode          = mode_code(n_mode);
    assign o_result.line          = n_line;
    assign o_result.coincidence   = n_coin;
    assign o_result.stat_irq      = stat;
    assign o_result.vblank_irq    = vbi;
    assign o_result.in_vblank     = n_vblank;
    assign o_result.render_strobe = rend;
    assign o_result.search_strobe = srch;

    // The vblank flag follows the mode exactly, since clearing the line keeps the mode.
    a_vblank_matches_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vblank == (r_mode == ST_VBLANK))
        else $error("vblank flag out of step with mode");

    a_acc_below_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_acc) < mode_length(r_mode))
        else $error("cycle accumulator reached the mode length");

    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> ($stable(r_mode) && $stable(r_line) && $stable(r_acc)))
        else $error("timing state changed without a transaction");

endmodule

`default_nettype wire

[design/lcd_mode_line_timing.sv]
`timescale 1ns / 1ps
`default_nettype none

// LCD mode and scanline timing.
// Input channel (i_valid/o_ready) carries one command per transaction: either
// advance by i_cycles elapsed clock cycles, saturated at MAX_CYCLES, or clear
// the line counter. Each input transaction produces exactly one result
// transaction (o_valid/i_ready) with the mode, line, coincidence flag, vblank
// flag, and the interrupt and strobe pulses caused by that command.
// An accepted command waits in the input register and feeds the timing update,
// which lands in the result register once that is free or being drained.
// Throughput is one item per cycle while the receiver keeps up; the single stage
// between the registers does the accumulate, mode length compare and line increment.
// When the receiver stalls, the result register holds and the input register
// keeps one more item, so o_ready drops only once both are full.
// Configuration uses an APB-style port: line_compare at 0x0, the status
// interrupt enables at 0x4. Write it only while the block is idle.
// Synchronous reset clears both registers stages, the configuration and the
// timing state (line 0, hblank, accumulator 0, flags clear).

module lcd_mode_line_timing
    import lcdt_pkg::*;
#(
    parameter int unsigned MAX_CYCLES = 24
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_command,
    input  wire logic [4:0]        i_cycles,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [1:0]        o_mode,
    output logic      [7:0]        o_line,
    output logic                   o_coincidence,
    output logic                   o_stat_irq,
    output logic                   o_vblank_irq,
    output logic                   o_in_vblank,
    output logic                   o_render_strobe,
    output logic                   o_search_strobe,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    t_cfg       cfg;
    t_result    step_result;
    t_result    r_out;
    logic       r_out_valid;
    logic       r_in_valid;
    logic       r_in_cmd;
    logic [4:0] r_in_cycles;
    logic       advance;

    lcdt_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lcdt_step #(
        .MAX_CYCLES (MAX_CYCLES)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_command (r_in_cmd),
        .i_cycles  (r_in_cycles),
        .i_cfg     (cfg),
        .o_result  (step_result)
    );

    // The held item moves on whenever the result register is free or being drained.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_cmd    <= i_command;
            r_in_cycles <= i_cycles;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_mode          = r_out.mode;
    assign o_line          = r_out.line;
    assign o_coincidence   = r_out.coincidence;
    assign o_stat_irq      = r_out.stat_irq;
    assign o_vblank_irq    = r_out.vblank_irq;
    assign o_in_vblank     = r_out.in_vblank;
    assign o_render_strobe = r_out.render_strobe;
    assign o_search_strobe = r_out.search_strobe;

    a_render_in_hblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_render_strobe) |-> (o_mode == MODE_HBLANK))
        else $error("render strobe without entering hblank");

    a_search_in_oam: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_search_strobe) |-> (o_mode == MODE_OAM && !o_in_vblank))
        else $error("search strobe without entering oam search");

    a_vblank_irq_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_vblank_irq) |->
            (o_in_vblank && o_line == LINE_VBLANK_START && o_mode == MODE_VBLANK))
        else $error("vblank interrupt outside vblank entry");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |-> !o_ready)
        else $error("input accepted with both stages full");

endmodule

`default_nettype wire

[tb/lcd_mode_line_timing_tb.sv]
`timescale 1ns / 1ps

module lcd_mode_line_timing_tb;
    import lcdt_pkg::*;

    localparam int unsigned SAT_CYCLES     = 24;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned RANDOM_CHUNKS  = 13;
    localparam int unsigned CHUNK_ITEMS    = 100;

    logic              i_clk;
    logic              i_rst_n   = 1'b0;
    logic              i_valid   = 1'b0;
    logic              i_command = 1'b0;
    logic [4:0]        i_cycles  = 5'd0;
    logic              i_ready   = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;

    logic              o_ready;
    logic              o_valid;
    logic [1:0]        o_mode;
    logic [7:0]        o_line;
    logic              o_coincidence;
    logic              o_stat_irq;
    logic              o_vblank_irq;
    logic              o_in_vblank;
    logic              o_render_strobe;
    logic              o_search_strobe;
    logic [31:0]       prdata;
    logic              pready;

    // Predicted timing state and register copy.
    t_cfg       cfg_m;
    logic [8:0] acc_m;
    logic [1:0] mode_m;
    logic [7:0] line_m;
    logic       coin_m;
    logic       vbl_m;

    t_result     line_status_q[$];
    logic        idling = 1'b1;
    int unsigned rx_wait;
    int unsigned idle_cycles;
    int unsigned n_items;
    int unsigned n_checked;
    int unsigned n_frames;
    int unsigned n_cfg_writes;
    int unsigned n_errors;

    lcd_mode_line_timing #(
        .MAX_CYCLES(SAT_CYCLES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_command(i_command),
        .i_cycles(i_cycles),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_mode(o_mode),
        .o_line(o_line),
        .o_coincidence(o_coincidence),
        .o_stat_irq(o_stat_irq),
        .o_vblank_irq(o_vblank_irq),
        .o_in_vblank(o_in_vblank),
        .o_render_strobe(o_render_strobe),
        .o_search_strobe(o_search_strobe),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Moves to the next line and updates the coincidence flag. Returns the
    // coincidence interrupt request.
    function automatic logic next_line();
        line_m = line_m + 8'd1;
        coin_m = (line_m == cfg_m.line_compare);
        return coin_m & cfg_m.stat_irq_enables[EN_LYC];
    endfunction

    function automatic t_result advance_timing(input logic cmd, input logic [4:0] cyc);
        t_result    r;
        logic [9:0] sum;
        logic [9:0] span;
        r = '0;
        if (cmd) begin
            line_m = 8'd0;
        end else begin
            sum = 10'(acc_m) + ((cyc > SAT_CYCLES) ? 10'(SAT_CYCLES) : 10'(cyc));
            case (mode_m)
                MODE_HBLANK: span = 10'(LEN_HBLANK);
                MODE_VBLANK: span = 10'(LEN_VBLANK);
                MODE_OAM:    span = 10'(LEN_OAM);
                default:     span = 10'(LEN_XFER);
            endcase
            if (sum >= span) begin
                sum = sum - span;
                case (mode_m)
                    MODE_HBLANK: begin
                        r.stat_irq = next_line();
                        if (line_m == LINE_VBLANK_START) begin
                            mode_m = MODE_VBLANK;
                            r.stat_irq |= cfg_m.stat_irq_enables[EN_VBLANK];
                            r.vblank_irq = 1'b1;
                            vbl_m = 1'b1;
                        end else begin
                            mode_m = MODE_OAM;
                            r.stat_irq |= cfg_m.stat_irq_enables[EN_OAM];
                            r.search_strobe = 1'b1;
                        end
                    end
                    MODE_VBLANK: begin
                        // The compare happens at line 154, before the wrap.
                        r.stat_irq = next_line();
                        if (line_m > LINE_LAST) begin
                            line_m = 8'd0;
                            mode_m = MODE_OAM;
                            r.stat_irq |= cfg_m.stat_irq_enables[EN_OAM];
                            r.search_strobe = 1'b1;
                            vbl_m = 1'b0;
                            n_frames++;
                        end
                    end
                    MODE_OAM: mode_m = MODE_XFER;
                    default: begin
                        mode_m = MODE_HBLANK;
                        r.render_strobe = 1'b1;
                        r.stat_irq = cfg_m.stat_irq_enables[EN_HBLANK];
                    end
                endcase
            end
            acc_m = sum[8:0];
        end
        r.mode        = mode_m;
        r.line        = line_m;
        r.coincidence = coin_m;
        r.in_vblank   = vbl_m;
        return r;
    endfunction

    task automatic send_item(input logic cmd, input logic [4:0] cyc);
        int unsigned gap;
        gap = idling ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_cycles  <= cyc;
        do @(posedge i_clk); while (!o_ready);
        line_status_q.push_back(advance_timing(cmd, cyc));
        n_items++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (line_status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LINE_COMPARE: cfg_m.line_compare     = value[7:0];
            REG_STAT_EN:      cfg_m.stat_irq_enables = value[3:0];
        endcase
        n_cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] lc, input logic [3:0] en);
        drain_results();
        write_reg(REG_LINE_COMPARE, 32'(lc));
        write_reg(REG_STAT_EN, 32'(en));
    endtask

    // Walks hblank, oam search and pixel transfer with saturating and
    // boundary cycle counts, with a line clear in the middle.
    task automatic test_directed_mode_walk();
        set_config(8'd1, 4'hF);
        idling = 1'b1;
        send_item(1'b0, 5'd0);
        send_item(1'b0, 5'd31);
        send_item(1'b0, 5'd25);
        send_item(1'b1, 5'd31);
        repeat (17) send_item(1'b0, 5'd24);
    endtask

    // Runs through a whole frame, so the compare at line 154 is seen.
    task automatic test_frame_wrap();
        int unsigned start;
        set_config(8'd154, 4'b1010);
        start = n_frames;
        while (n_frames == start) begin
            idling = (line_m >= 8'd140) || vbl_m;
            send_item(1'b0, 5'($urandom_range(20, 31)));
        end
    endtask

    // Clears the line partway through vblank; vblank must run on until the
    // line passes 153 again.
    task automatic test_clear_in_vblank();
        set_config(8'd144, 4'b1011);
        idling = 1'b0;
        while (!(vbl_m && line_m == 8'd147))
            send_item(1'b0, 5'($urandom_range(22, 31)));
        send_item(1'b1, 5'($urandom_range(0, 31)));
        while (vbl_m) begin
            idling = (line_m >= 8'd140);
            send_item(1'b0, 5'($urandom_range(20, 31)));
        end
    endtask

    task automatic test_random_traffic();
        logic [7:0] lc;
        logic [3:0] en;
        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            case ($urandom_range(0, 4))
                0:       lc = 8'd0;
                1:       lc = 8'd255;
                2:       lc = 8'($urandom_range(153, 154));
                default: lc = 8'($urandom_range(0, 40));
            endcase
            if (chunk == 0)
                en = 4'h0;
            else if (chunk == 1)
                en = 4'hF;
            else
                en = 4'($urandom_range(0, 15));
            // The sender waits here for every outstanding result.
            set_config(lc, en);
            idling = (chunk % 4 != 3);
            repeat (CHUNK_ITEMS)
                send_item($urandom_range(0, 19) == 0, 5'($urandom_range(0, 31)));
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_side
        t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (line_status_q.size() == 0) begin
                    $display("%0t: result transaction with none expected, actual line %0d",
                             $time, o_line);
                    n_errors++;
                end else begin
                    want = line_status_q.pop_front();
                    check_field("mode", want.mode, o_mode);
                    check_field("line", want.line, o_line);
                    check_field("coincidence", want.coincidence, o_coincidence);
                    check_field("stat_irq", want.stat_irq, o_stat_irq);
                    check_field("vblank_irq", want.vblank_irq, o_vblank_irq);
                    check_field("in_vblank", want.in_vblank, o_in_vblank);
                    check_field("render_strobe", want.render_strobe, o_render_strobe);
                    check_field("search_strobe", want.search_strobe, o_search_strobe);
                    n_checked++;
                end
                rx_wait = idling ? $urandom_range(0, 9) : 0;
            end
            if (rx_wait > 0) begin
                i_ready <= 1'b0;
                rx_wait--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        cfg_m  = '0;
        acc_m  = '0;
        mode_m = MODE_HBLANK;
        line_m = '0;
        coin_m = 1'b0;
        vbl_m  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_mode_walk();
        test_frame_wrap();
        test_clear_in_vblank();
        test_random_traffic();
        drain_results();
        $display("Sent %0d commands, checked %0d results, %0d frame wraps seen.",
                 n_items, n_checked, n_frames);
        $display("Covered a line clear in vblank and %0d register writes.", n_cfg_writes);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
design/lcdt_pkg.sv
design/lcdt_apb.sv
design/lcdt_step.sv
design/lcd_mode_line_timing.sv
tb/lcd_mode_line_timing_tb.sv
